FILE: sv/iir_direct_form_filter_assert.svh
// Assertion macros shared by the filter RTL.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef IIR_DIRECT_FORM_FILTER_ASSERT_SVH
`define IIR_DIRECT_FORM_FILTER_ASSERT_SVH

// The property must hold in the same cycle as the trigger.
`define IIRDF_ASSERT_IMP(name, trig, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the trigger.
`define IIRDF_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: sv/iirdf_pkg.sv
`default_nettype none

package iirdf_pkg;

  // Word kinds carried on the slave tuser.
  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_LOAD_A = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_FF_TAPS = 1'b0;
  localparam logic CFG_FB_TAPS = 1'b1;

  // Bank select bit of the coefficient and history memories.
  localparam logic BANK_FF = 1'b0;
  localparam logic BANK_FB = 1'b1;
  localparam logic BANK_X  = 1'b0;
  localparam logic BANK_Y  = 1'b1;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int TAP_REG_W = 5;
  localparam int FRAC_SH   = 14;

  typedef struct packed {
    logic clear;
    logic valid;
    logic sub;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

`default_nettype wire

FILE: sv/iir_direct_form_filter.sv
// Direct-form I IIR filter with Q1.15 samples and Q4.14 coefficients.
// Slave stream: tuser carries the word kind. A filter word shifts sample_in
// into the input history and produces one output word; a load word writes
// coef_value into the feedforward or feedback table at coef_index (indexes
// at or above MAX_TAPS are dropped) and produces nothing. Kind 3 is ignored.
// Master stream: tdata is the saturated Q1.15 sample, tuser[0] is set when
// the rounded sum had to be clipped.
// Configuration: cfg_index_i 0 sets the feedforward tap count Nb, 1 sets the
// feedback table length Na (1 means no feedback). Counts clamp to 1..MAX_TAPS.
// Timing: one multiply-accumulate per tap through a single shared MAC fed by
// the coefficient and history memories, one memory read a cycle each. The
// slave side is ready again from the same edge that loads a filter word's
// output, so a new filter word is accepted only once the last has finished.
// A load word is written at acceptance and leaves the slave side ready.
// If the master side stalls, the finished word waits in the output register
// while the next words are accepted; a following filter word holds in its final
// step until that register drains. Reset empties both histories, zeroes both
// coefficient tables and sets both tap counts to 1.
`default_nettype none

`include "iir_direct_form_filter_assert.svh"

module iir_direct_form_filter #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_data_i,
  // Slave stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] coef_index, [21:4] coef_value, [37:22] sample_in, [39:38] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  // Master stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] sample_out
  output logic [15:0]      m_axis_tdata,
  // [0] clipped
  output logic [0:0]       m_axis_tuser
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW    = (MAX_TAPS > 1) ? $clog2(2 * MAX_TAPS) : 1;
  localparam int ACC_W = iirdf_pkg::PROD_W + $clog2(2 * MAX_TAPS) + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Input word fields.
  logic [3:0]                     in_index;
  logic [iirdf_pkg::COEF_W-1:0]   in_coef;
  logic [iirdf_pkg::SAMPLE_W-1:0] in_sample;
  logic                           in_fire, filter_fire, load_fire;

  assign in_index  = s_axis_tdata[3:0];
  assign in_coef   = s_axis_tdata[21:4];
  assign in_sample = s_axis_tdata[37:22];

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [AW-1:0] xp_q, xp_d, yp_q, yp_d;
  logic [iirdf_pkg::TAP_REG_W-1:0] ff_taps_q, fb_taps_q;
  logic          rd_v_q, rd_sub_q;
  logic          m_valid_q, m_valid_d, m_clip_q;
  logic [iirdf_pkg::SAMPLE_W-1:0] m_data_q;

  logic [SW-1:0] nb, na, total, fb_step;
  logic          ff_phase, issue, out_free;

  logic          coef_we, hist_we;
  logic [AW:0]   coef_waddr, coef_raddr, hist_waddr, hist_raddr;
  logic [iirdf_pkg::SAMPLE_W-1:0] hist_wdata, hist_rdata;
  logic [iirdf_pkg::COEF_W-1:0]   coef_rdata;

  iirdf_pkg::mac_ctrl_t mac_ctrl;
  iirdf_pkg::mac_stat_t mac_stat;
  logic [iirdf_pkg::SAMPLE_W-1:0] mac_result;
  logic                           mac_clip;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign filter_fire   = in_fire && (s_axis_tuser == iirdf_pkg::OP_FILTER);
  assign load_fire     = in_fire && ((s_axis_tuser == iirdf_pkg::OP_LOAD_B) ||
                                     (s_axis_tuser == iirdf_pkg::OP_LOAD_A));

  // Tap counts clamped into 1..MAX_TAPS.
  always_comb begin
    if (ff_taps_q == '0) begin
      nb = SW'(1);
    end else if (int'(ff_taps_q) > MAX_TAPS) begin
      nb = SW'(MAX_TAPS);
    end else begin
      nb = SW'(ff_taps_q);
    end
    if (fb_taps_q == '0) begin
      na = SW'(1);
    end else if (int'(fb_taps_q) > MAX_TAPS) begin
      na = SW'(MAX_TAPS);
    end else begin
      na = SW'(fb_taps_q);
    end
  end

  // One step per feedforward tap, then one per feedback tap a[1]..a[Na-1].
  assign total    = nb + na - SW'(1);
  assign ff_phase = (step_q < nb);
  assign fb_step  = step_q - nb;
  assign issue    = (state_q == ST_RUN);
  assign out_free = !m_valid_q || m_axis_tready;

  // Coefficient tables share one memory: bank bit on top of the tap index.
  assign coef_we    = load_fire && (int'(in_index) < MAX_TAPS);
  assign coef_waddr = {(s_axis_tuser == iirdf_pkg::OP_LOAD_A) ? iirdf_pkg::BANK_FB
                                                              : iirdf_pkg::BANK_FF,
                       AW'(in_index)};
  assign coef_raddr = ff_phase ? {iirdf_pkg::BANK_FF, step_q[AW-1:0]}
                               : {iirdf_pkg::BANK_FB, fb_step[AW-1:0] + AW'(1)};

  // Histories are circular buffers: xp_q points at x[n], yp_q at y[n-1].
  // The new sample is written at acceptance, so the reads that start in the
  // next cycle already see it.
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {iirdf_pkg::BANK_X, xp_q + AW'(1)};
    hist_wdata = in_sample;
    if (filter_fire) begin
      hist_we = 1'b1;
    end else if ((state_q == ST_FIN) && out_free) begin
      hist_we    = 1'b1;
      hist_waddr = {iirdf_pkg::BANK_Y, yp_q + AW'(1)};
      hist_wdata = mac_result;
    end
  end

  assign hist_raddr = ff_phase ? {iirdf_pkg::BANK_X, xp_q - step_q[AW-1:0]}
                               : {iirdf_pkg::BANK_Y, yp_q - fb_step[AW-1:0]};

  iirdf_ram #(
    .W  (iirdf_pkg::COEF_W),
    .AW (AW + 1)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_coef),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  iirdf_ram #(
    .W  (iirdf_pkg::SAMPLE_W),
    .AW (AW + 1)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // The MAC sees read data in the cycle after the address was issued.
  assign mac_ctrl.clear = filter_fire;
  assign mac_ctrl.valid = rd_v_q;
  assign mac_ctrl.sub   = rd_sub_q;

  iirdf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (signed'(coef_rdata)),
    .data_i   (signed'(hist_rdata)),
    .stat_o   (mac_stat),
    .result_o (mac_result),
    .clip_o   (mac_clip)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    xp_d      = xp_q;
    yp_d      = yp_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (filter_fire) begin
          xp_d    = xp_q + AW'(1);
          step_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == total - SW'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mac_stat.busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          yp_d      = yp_q + AW'(1);
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      xp_q      <= '0;
      yp_q      <= '0;
      rd_v_q    <= 1'b0;
      rd_sub_q  <= 1'b0;
      m_valid_q <= 1'b0;
      ff_taps_q <= iirdf_pkg::TAP_REG_W'(1);
      fb_taps_q <= iirdf_pkg::TAP_REG_W'(1);
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      xp_q      <= xp_d;
      yp_q      <= yp_d;
      rd_v_q    <= issue;
      rd_sub_q  <= !ff_phase;
      m_valid_q <= m_valid_d;
      if (cfg_we_i && (cfg_index_i == iirdf_pkg::CFG_FF_TAPS)) begin
        ff_taps_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == iirdf_pkg::CFG_FB_TAPS)) begin
        fb_taps_q <= cfg_data_i;
      end
    end
  end

  // Output register, loaded only when it is free.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      m_data_q <= mac_result;
      m_clip_q <= mac_clip;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_clip_q;

  `IIRDF_ASSERT_NEXT(a_filter_starts, filter_fire, state_q == ST_RUN, "sweep not started")
  `IIRDF_ASSERT_IMP(a_step_bound, state_q == ST_RUN, step_q < total, "step past tap count")
  `IIRDF_ASSERT_IMP(a_fin_drained, state_q == ST_FIN, !rd_v_q && !mac_stat.busy, "MAC busy")
  `IIRDF_ASSERT_NEXT(a_xp_hold, !filter_fire, $stable(xp_q), "history pointer moved")
  `IIRDF_ASSERT_NEXT(a_out_hold, (state_q == ST_FIN) && !out_free, state_q == ST_FIN, "word lost")

endmodule

`default_nettype wire

FILE: sv/iirdf_ram.sv
`default_nettype none

// Single-port-write, single-port-read synchronous memory with a registered
// read. Entries that were never written since reset read as zero.
module iirdf_ram #(
  parameter int W  = 16,
  parameter int AW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0]     mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [W-1:0]     rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: sv/iirdf_mac.sv
`default_nettype none

// Shared multiply-accumulate: a registered product, then a wide accumulator.
// The rounded and saturated view of the accumulator is always available.
module iirdf_mac #(
  parameter int ACC_W = 40
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire iirdf_pkg::mac_ctrl_t                 ctrl_i,
  input  wire logic signed [iirdf_pkg::COEF_W-1:0]   coef_i,
  input  wire logic signed [iirdf_pkg::SAMPLE_W-1:0] data_i,
  output iirdf_pkg::mac_stat_t                      stat_o,
  output logic [iirdf_pkg::SAMPLE_W-1:0]            result_o,
  output logic                                      clip_o
);

  localparam int SW = iirdf_pkg::SAMPLE_W;

  logic signed [iirdf_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                                p_v_q, p_sub_q;
  logic signed [ACC_W-1:0]             acc_q, acc_d;
  logic signed [ACC_W-1:0]             rounded, shifted;
  logic [ACC_W-SW:0]                   hi_bits;

  assign prod_d = coef_i * data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      p_sub_q <= 1'b0;
    end else begin
      p_v_q   <= ctrl_i.valid;
      p_sub_q <= ctrl_i.sub;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (p_v_q) begin
      if (p_sub_q) begin
        acc_d = acc_q - ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Round half up, then floor to Q1.15 with an arithmetic shift.
  assign rounded = acc_q + ACC_W'(2 ** (iirdf_pkg::FRAC_SH - 1));
  assign shifted = rounded >>> iirdf_pkg::FRAC_SH;
  assign hi_bits = shifted[ACC_W-1:SW-1];

  always_comb begin
    if ((hi_bits == '0) || (hi_bits == '1)) begin
      result_o = shifted[SW-1:0];
      clip_o   = 1'b0;
    end else begin
      result_o = shifted[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      clip_o   = 1'b1;
    end
  end

  assign stat_o.busy = p_v_q | ctrl_i.valid;

endmodule

`default_nettype wire
